>>> rtl/core/text_console_cursor_engine_top_defines.svh
// Assertion macros shared by the text console cursor engine RTL.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Checked at every clock edge outside reset.
`define TCCE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define TCCE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/tcce_pkg.sv
// Package for the text console cursor engine: character codes, cell geometry,
// register indexes, reset values and the step result type. Depends on nothing.
package tcce_pkg;

	// Field widths.
	localparam int unsigned CharW   = 8;
	localparam int unsigned GlyphW  = 7;
	localparam int unsigned ColW    = 8;
	localparam int unsigned RowW    = 7;
	localparam int unsigned ScanW   = 13;
	localparam int unsigned OffW    = 24;
	localparam int unsigned ColourW = 32;
	localparam int unsigned CfgIdxW = 3;

	// Default geometry limits.
	localparam int unsigned DEF_MAX_COLUMNS = 255;
	localparam int unsigned DEF_MAX_ROWS    = 127;

	// Character codes.
	localparam logic [CharW-1:0] CHAR_BS       = 8'd8;
	localparam logic [CharW-1:0] CHAR_LF       = 8'd10;
	localparam logic [CharW-1:0] CHAR_CR       = 8'd13;
	localparam logic [CharW-1:0] CHAR_PRINT_LO = 8'd32;
	localparam logic [CharW-1:0] CHAR_PRINT_HI = 8'd126;
	localparam logic [GlyphW-1:0] GLYPH_BLANK  = 7'd32;
	localparam logic [GlyphW-1:0] GLYPH_NONE   = 7'd0;

	// Cell geometry in pixels: 9 wide, 16 tall (row scale is a shift by 4).
	localparam int unsigned CellHShift = 4;
	localparam logic [10:0] PAD_PIX    = 11'd6;

	// Command kinds.
	localparam logic ACT_DRAW   = 1'b0;
	localparam logic ACT_SCROLL = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_TEXT_COLUMNS = 3'd0,
		REG_TEXT_ROWS    = 3'd1,
		REG_SCAN_WIDTH   = 3'd2,
		REG_FG_COLOUR    = 3'd3,
		REG_BG_COLOUR    = 3'd4
	} reg_idx_t;

	// Register reset values.
	localparam logic [ColW-1:0]    RST_TEXT_COLUMNS = 8'd112;
	localparam logic [RowW-1:0]    RST_TEXT_ROWS    = 7'd47;
	localparam logic [ScanW-1:0]   RST_SCAN_WIDTH   = 13'd1024;
	localparam logic [ColourW-1:0] RST_FG_COLOUR    = 32'h00E0E0E0;
	localparam logic [ColourW-1:0] RST_BG_COLOUR    = 32'h00080808;

	// What one character does to the cursor and which commands it raises.
	typedef struct packed {
		logic              draw_v;
		logic              scroll_v;
		logic [GlyphW-1:0] glyph;
		logic [ColW-1:0]   draw_col;
		logic [RowW-1:0]   draw_row;
		logic [OffW-1:0]   draw_off;
		logic [ColW-1:0]   next_col;
		logic [RowW-1:0]   next_row;
	} step_t;

endpackage

>>> rtl/core/text_console_cursor_engine_top.sv
// Top level of the text console cursor engine: input word register, cursor
// state, configuration registers and the two-slot result register.
// Uses tcce_pkg, tcce_step and text_console_cursor_engine_top_defines.svh.
//
// The block reads one character byte per input word on the s_axis channel and
// writes console commands on the m_axis channel: a glyph draw for a cell, or a
// scroll-up of one text row. tuser carries the command kind (0 draw, 1 scroll)
// and tlast marks the final command raised by one character. A printable code
// at the end of the last row raises a draw followed by a scroll; every other
// character raises at most one command, and many raise none.
// A character accepted into the input register is decoded from there into the
// result register, which drives its first command on the output.
// A character with a draw and a scroll sends both commands in turn, one output
// word per cycle while the receiver is ready.
// The next character is accepted while a result still waits on the output.
// When the receiver stalls, the result register holds, the input register
// fills, and s_axis_tready falls until the result register can take a new pair.
// Reset clears the cursor to column 0, row 0, empties both registers, and loads
// the geometry and colour registers with their defaults (112 columns, 47 rows,
// 1024 words per line). The cfg channel is always ready and must only be used
// while the block is idle.
module text_console_cursor_engine_top #(
	parameter int unsigned MAX_COLUMNS = tcce_pkg::DEF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS    = tcce_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Character input; tdata: char_code[7:0].
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,
	// Commands; tdata: glyph[6:0], cell_column[14:7], cell_row[21:15],
	// pixel_offset[45:22], draw_fg[77:46], draw_bg[109:78], zero[111:110].
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [111:0]                  m_axis_tdata,
	// tuser: action[0].
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast,
	// Configuration writes.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tcce_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]                   cfg_data
);
	import tcce_pkg::*;

	`include "text_console_cursor_engine_top_defines.svh"

	localparam logic [ColW-1:0] MaxCols = ColW'(MAX_COLUMNS);
	localparam logic [RowW-1:0] MaxRows = RowW'(MAX_ROWS);

	// Configuration registers.
	logic [ColW-1:0]    text_columns_q;
	logic [RowW-1:0]    text_rows_q;
	logic [ScanW-1:0]   scan_width_q;
	logic [ColourW-1:0] fg_colour_q;
	logic [ColourW-1:0] bg_colour_q;
	logic [ColW-1:0]    eff_cols;
	logic [RowW-1:0]    eff_rows;
	logic [RowW-1:0]    last_row;
	logic [10:0]        scroll_pix_row;
	logic [OffW-1:0]    scroll_off_q;

	// Input register and cursor.
	logic               valid_s1;
	logic [CharW-1:0]   char_s1;
	logic [ColW-1:0]    cursor_col_q;
	logic [RowW-1:0]    cursor_row_q;
	step_t              step_res;

	// Result register: slot 0 holds the draw, slot 1 marks a pending scroll.
	logic               draw_v_q;
	logic               scroll_v_q;
	logic [GlyphW-1:0]  glyph_q;
	logic [ColW-1:0]    draw_col_q;
	logic [RowW-1:0]    draw_row_q;
	logic [OffW-1:0]    draw_off_q;

	logic               out_fire;
	logic               pair_free;
	logic               adv_s1;
	logic               act;
	logic [GlyphW-1:0]  o_glyph;
	logic [ColW-1:0]    o_col;
	logic [RowW-1:0]    o_row;
	logic [OffW-1:0]    o_off;
	logic [ColourW-1:0] o_fg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_columns_q <= RST_TEXT_COLUMNS;
			text_rows_q    <= RST_TEXT_ROWS;
			scan_width_q   <= RST_SCAN_WIDTH;
			fg_colour_q    <= RST_FG_COLOUR;
			bg_colour_q    <= RST_BG_COLOUR;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEXT_COLUMNS: text_columns_q <= cfg_data[ColW-1:0];
				REG_TEXT_ROWS:    text_rows_q    <= cfg_data[RowW-1:0];
				REG_SCAN_WIDTH:   scan_width_q   <= cfg_data[ScanW-1:0];
				REG_FG_COLOUR:    fg_colour_q    <= cfg_data;
				REG_BG_COLOUR:    bg_colour_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Geometry is clamped to one cell at least and to the build limits at most.
	always_comb begin
		eff_cols = text_columns_q;
		if (eff_cols > MaxCols) eff_cols = MaxCols;
		if (eff_cols == '0) eff_cols = 8'd1;
		eff_rows = text_rows_q;
		if (eff_rows > MaxRows) eff_rows = MaxRows;
		if (eff_rows == '0) eff_rows = 7'd1;
	end

	// The scroll offset depends only on configuration, so it is kept in a
	// register that is loaded from the configuration registers.
	assign last_row       = eff_rows - 7'd1;
	assign scroll_pix_row = {last_row, {CellHShift{1'b0}}} + PAD_PIX;

	always_ff @(posedge clk) begin
		scroll_off_q <= OffW'(scroll_pix_row * scan_width_q);
	end

	// Handshakes. The result register takes a new pair when empty, or when its
	// only remaining command leaves in this cycle.
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign pair_free     = (!draw_v_q && !scroll_v_q) ||
	                       (out_fire && (draw_v_q ^ scroll_v_q));
	assign adv_s1        = valid_s1 && pair_free;
	assign s_axis_tready = !valid_s1 || adv_s1;

	tcce_step u_step (
		.char_code  (char_s1),
		.cur_col    (cursor_col_q),
		.cur_row    (cursor_row_q),
		.eff_cols   (eff_cols),
		.eff_rows   (eff_rows),
		.scan_width (scan_width_q),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			draw_v_q     <= 1'b0;
			scroll_v_q   <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				cursor_col_q <= step_res.next_col;
				cursor_row_q <= step_res.next_row;
				draw_v_q     <= step_res.draw_v;
				scroll_v_q   <= step_res.scroll_v;
			end else if (out_fire) begin
				if (draw_v_q) begin
					draw_v_q <= 1'b0;
				end else begin
					scroll_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
		end
		if (adv_s1) begin
			glyph_q    <= step_res.glyph;
			draw_col_q <= step_res.draw_col;
			draw_row_q <= step_res.draw_row;
			draw_off_q <= step_res.draw_off;
		end
	end

	// Output word: the draw goes first, the scroll after it.
	always_comb begin
		if (draw_v_q) begin
			act     = ACT_DRAW;
			o_glyph = glyph_q;
			o_col   = draw_col_q;
			o_row   = draw_row_q;
			o_off   = draw_off_q;
			o_fg    = fg_colour_q;
		end else begin
			act     = ACT_SCROLL;
			o_glyph = GLYPH_NONE;
			o_col   = '0;
			o_row   = last_row;
			o_off   = scroll_off_q;
			o_fg    = '0;
		end
	end

	assign m_axis_tvalid = draw_v_q || scroll_v_q;
	assign m_axis_tuser  = act;
	assign m_axis_tlast  = !(draw_v_q && scroll_v_q);
	assign m_axis_tdata  = {2'b00, bg_colour_q, o_fg, o_off, o_row, o_col, o_glyph};

	`TCCE_ASSERT(a_scroll_is_last, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "scroll not last")
	`TCCE_ASSERT(a_pair_continues, (out_fire && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tuser), "second command of a pair missing")
	`TCCE_ASSERT(a_cursor_moves_on_step, (!$stable(cursor_col_q) || !$stable(cursor_row_q)) |-> $past(adv_s1), "cursor moved without a character")

endmodule

>>> rtl/core/tcce_step.sv
// Cursor step logic of the text console cursor engine: decodes one character,
// moves the cursor and forms the draw cell and its pixel word offset. Uses tcce_pkg.
module tcce_step (
	input  logic [tcce_pkg::CharW-1:0] char_code,
	input  logic [tcce_pkg::ColW-1:0]  cur_col,
	input  logic [tcce_pkg::RowW-1:0]  cur_row,
	input  logic [tcce_pkg::ColW-1:0]  eff_cols,
	input  logic [tcce_pkg::RowW-1:0]  eff_rows,
	input  logic [tcce_pkg::ScanW-1:0] scan_width,
	output tcce_pkg::step_t            res
);
	import tcce_pkg::*;

	logic [ColW:0]   col_inc;
	logic [RowW:0]   row_inc;
	logic            wrap_col;
	logic            nl_scroll;
	logic [RowW-1:0] nl_row;
	logic [10:0]     pix_row;
	logic [11:0]     pix_col;
	logic [23:0]     row_prod;
	step_t           base;

	assign col_inc   = {1'b0, cur_col} + 9'd1;
	assign row_inc   = {1'b0, cur_row} + 8'd1;
	assign wrap_col  = col_inc >= {1'b0, eff_cols};
	assign nl_scroll = row_inc >= {1'b0, eff_rows};
	assign nl_row    = nl_scroll ? (eff_rows - 7'd1) : row_inc[RowW-1:0];

	always_comb begin
		base          = '0;
		base.glyph    = GLYPH_BLANK;
		base.draw_col = cur_col;
		base.draw_row = cur_row;
		base.next_col = cur_col;
		base.next_row = cur_row;
		case (char_code) inside
			[CHAR_PRINT_LO:CHAR_PRINT_HI]: begin
				base.draw_v = 1'b1;
				base.glyph  = char_code[GlyphW-1:0];
				if (wrap_col) begin
					base.next_col = '0;
					base.next_row = nl_row;
					base.scroll_v = nl_scroll;
				end else begin
					base.next_col = col_inc[ColW-1:0];
				end
			end
			CHAR_CR: begin
				base.next_col = '0;
			end
			CHAR_LF: begin
				base.next_col = '0;
				base.next_row = nl_row;
				base.scroll_v = nl_scroll;
			end
			CHAR_BS: begin
				// Step back; at column zero go to the end of the row above, if there is one.
				if (cur_col != '0) begin
					base.draw_v   = 1'b1;
					base.next_col = cur_col - 8'd1;
					base.draw_col = cur_col - 8'd1;
				end else if (cur_row != '0) begin
					base.draw_v   = 1'b1;
					base.next_row = cur_row - 7'd1;
					base.next_col = eff_cols - 8'd1;
					base.draw_row = cur_row - 7'd1;
					base.draw_col = eff_cols - 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Top-left pixel: (row*16 + 6) * scan_width + col*9 + 6, kept to 24 bits.
	assign pix_row  = {base.draw_row, {CellHShift{1'b0}}} + PAD_PIX;
	assign pix_col  = {1'b0, base.draw_col, 3'b000} + {4'b0000, base.draw_col}
	                  + {1'b0, PAD_PIX};
	assign row_prod = {13'd0, pix_row} * {11'd0, scan_width};

	always_comb begin
		res          = base;
		res.draw_off = row_prod + {12'd0, pix_col};
	end

endmodule
